// File: design/ffa_pkg.sv
package ffa_pkg;

  localparam int MaxBlocks   = 64;
  localparam int IdxW        = 6;
  localparam int CntW        = 7;
  localparam int OffW        = 20;
  localparam int HeaderBytes = 32;
  localparam int AlignBytes  = 8;
  localparam int MinPayload  = 16;
  localparam int EntryW      = OffW + OffW + 1;

  localparam logic [1:0] OP_INIT    = 2'd0;
  localparam logic [1:0] OP_ALLOC   = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_UNINIT   = 2'd1;
  localparam logic [1:0] ST_NOFIT    = 2'd2;
  localparam logic [1:0] ST_BADREL   = 2'd3;

  localparam logic CFG_BASE  = 1'b0;
  localparam logic CFG_BYTES = 1'b1;

  typedef struct packed {
    logic [OffW-1:0] offset;
    logic [OffW-1:0] size;
    logic            free;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH_RD,
    S_SEARCH,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_SPLIT,
    S_REL_NEXT,
    S_REL_NEXT_CHK,
    S_REL_PREV_CHK,
    S_STAT_RD,
    S_STAT,
    S_DONE
  } state_t;

endpackage

// File: design/ffa_if.sv
interface ffa_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [20:0] request_size;
  logic [31:0] release_address;
  modport source (output valid, operation, request_size, release_address, input ready);
  modport sink   (input valid, operation, request_size, release_address, output ready);
endinterface

interface ffa_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] granted_address;
  logic [1:0]  status;
  logic [20:0] used_bytes;
  logic [6:0]  total_blocks;
  logic [6:0]  free_blocks;
  logic [20:0] largest_free;
  modport source (output valid, granted_address, status, used_bytes, total_blocks,
                  free_blocks, largest_free, input ready);
  modport sink   (input valid, granted_address, status, used_bytes, total_blocks,
                  free_blocks, largest_free, output ready);
endinterface

interface ffa_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: design/ffa_ram.sv
module ffa_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/first_fit_heap_allocator.sv
// Operation: each operation ends with a statistics pass over the entries left
//   afterwards; a search reads the entries in order, and a split or merge moves
//   the entries behind it one by one. The longest operation is a release near the
//   start of a full table that merges on both sides.
// Throughput: one operation at a time; the next beat is taken the cycle after the
//   result beat leaves. All table scans go through one RAM read port.
// Reset: synchronous active-low rst_n clears control, counters and the configuration
//   registers; the table contents are undefined until an initialise writes them.
module first_fit_heap_allocator
  import ffa_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  ffa_in_if.sink        in_ch,
  ffa_out_if.source     out_ch,
  ffa_cfg_if.sink       cfg_ch
);

  state_t state_r, state_nxt;

  logic [31:0]     base_r;
  logic [20:0]     bytes_r;
  logic [CntW-1:0] count_r, count_nxt;
  logic [OffW-1:0] used_r, used_nxt;
  logic            ready_r, ready_nxt;

  logic [1:0]      op_r, op_nxt;
  logic [OffW+1:0] need_r, need_nxt;
  logic [31:0]     rel_r, rel_nxt;
  logic [CntW-1:0] idx_r, idx_nxt;
  logic [CntW-1:0] hit_r, hit_nxt;
  logic [CntW-1:0] stop_r, stop_nxt;
  entry_t          hold_r, hold_nxt;
  entry_t          cur_r, cur_nxt;
  logic            mode_r, mode_nxt;  // shift direction: 1 open gap, 0 close gap
  logic            phase_r, phase_nxt; // release: 0 after successor, 1 after predecessor

  logic [1:0]      st_r, st_nxt;
  logic [31:0]     addr_r, addr_nxt;
  logic [CntW-1:0] nfree_r, nfree_nxt;
  logic [OffW-1:0] big_r, big_nxt;
  logic            oval_r, oval_nxt;

  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  entry_t          wdata, rdata;

  ffa_ram #(.Width(EntryW), .Depth(MaxBlocks)) u_tab (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign in_ch.ready  = (state_r == S_IDLE) && !oval_r;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = oval_r;
  assign out_ch.granted_address = addr_r;
  assign out_ch.status          = st_r;
  assign out_ch.used_bytes      = {1'b0, used_r};
  assign out_ch.total_blocks    = count_r;
  assign out_ch.free_blocks     = nfree_r;
  assign out_ch.largest_free    = {1'b0, big_r};

  logic [OffW+1:0] req_up;
  logic [20:0] hb_clip;
  logic [OffW+1:0] rem;
  logic [31:0] paddr;
  assign req_up  = ({1'b0, in_ch.request_size} + 22'(AlignBytes - 1)) &
                   ~22'(AlignBytes - 1);
  assign hb_clip = bytes_r[20] ? 21'h100000 : bytes_r;
  assign rem     = {2'b0, rdata.size} - need_r;
  assign paddr   = base_r + 32'(rdata.offset) + 32'(HeaderBytes);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    used_nxt  = used_r;
    ready_nxt = ready_r;
    op_nxt    = op_r;
    need_nxt  = need_r;
    rel_nxt   = rel_r;
    idx_nxt   = idx_r;
    hit_nxt   = hit_r;
    stop_nxt  = stop_r;
    hold_nxt  = hold_r;
    cur_nxt   = cur_r;
    mode_nxt  = mode_r;
    phase_nxt = phase_r;
    st_nxt    = st_r;
    addr_nxt  = addr_r;
    nfree_nxt = nfree_r;
    big_nxt   = big_r;
    oval_nxt  = oval_r;
    we        = 1'b0;
    waddr     = idx_r[IdxW-1:0];
    wdata     = hold_r;
    raddr     = idx_r[IdxW-1:0];
    if (oval_r && out_ch.ready) begin
      oval_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid && !oval_r) begin
          op_nxt   = in_ch.operation;
          rel_nxt  = in_ch.release_address;
          need_nxt = (req_up < 22'(MinPayload)) ? 22'(MinPayload) : req_up;
          addr_nxt = '0;
          idx_nxt  = '0;
          raddr    = '0;
          state_nxt = S_STAT_RD;
          unique case (in_ch.operation)
            OP_INIT: begin
              used_nxt  = '0;
              if (hb_clip < 21'(HeaderBytes)) begin
                count_nxt = '0;
                ready_nxt = 1'b0;
                st_nxt    = ST_UNINIT;
              end else begin
                we        = 1'b1;
                waddr     = '0;
                wdata     = '{offset: '0, size: OffW'(hb_clip - 21'(HeaderBytes)), free: 1'b1};
                count_nxt = CntW'(1);
                ready_nxt = 1'b1;
                st_nxt    = ST_OK;
              end
            end
            OP_ALLOC: begin
              if (!ready_r || in_ch.request_size == '0) begin
                st_nxt = ST_UNINIT;
              end else begin
                state_nxt = S_SEARCH_RD;
              end
            end
            OP_RELEASE: begin
              if (!ready_r) begin
                st_nxt = ST_UNINIT;
              end else begin
                state_nxt = S_SEARCH_RD;
              end
            end
            default: st_nxt = ST_UNINIT;
          endcase
        end
      end
      // read entry idx; its data appears next cycle
      S_SEARCH_RD: begin
        if (idx_r >= count_r) begin
          st_nxt    = (op_r == OP_ALLOC) ? ST_NOFIT : ST_BADREL;
          idx_nxt   = '0;
          state_nxt = S_STAT_RD;
        end else begin
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (op_r == OP_ALLOC && rdata.free && !rem[OffW+1]) begin
          hit_nxt = idx_r;
          cur_nxt = rdata;
          st_nxt  = ST_OK;
          if (rem[OffW-1:0] >= OffW'(HeaderBytes + MinPayload) &&
              count_r < CntW'(MaxBlocks)) begin
            // open a gap at hit+1 by moving tail up, from the end down
            hold_nxt  = '{offset: rdata.offset + OffW'(HeaderBytes) + need_r[OffW-1:0],
                          size: rem[OffW-1:0] - OffW'(HeaderBytes), free: 1'b1};
            mode_nxt  = 1'b1;
            idx_nxt   = count_r - CntW'(1);
            stop_nxt  = idx_r;
            state_nxt = S_SHIFT_RD;
          end else begin
            state_nxt = S_SPLIT;
          end
        end else if (op_r == OP_RELEASE && !rdata.free && paddr == rel_r) begin
          hit_nxt   = idx_r;
          cur_nxt   = rdata;
          st_nxt    = ST_OK;
          used_nxt  = used_r - rdata.size;
          phase_nxt = 1'b0;
          idx_nxt   = idx_r + CntW'(1);
          state_nxt = S_REL_NEXT;
        end else begin
          idx_nxt   = idx_r + CntW'(1);
          state_nxt = S_SEARCH_RD;
        end
      end
      // entry move: read in S_SHIFT_RD, write in S_SHIFT_WR
      S_SHIFT_RD: begin
        if (mode_r ? (idx_r == stop_r) : (idx_r >= count_r)) begin
          if (mode_r) begin
            we        = 1'b1;
            waddr     = IdxW'(stop_r + CntW'(1));
            wdata     = hold_r;
            count_nxt = count_r + CntW'(1);
            cur_nxt.size = need_r[OffW-1:0];
            state_nxt = S_SPLIT;
          end else begin
            count_nxt = count_r - CntW'(1);
            if (phase_r) begin
              idx_nxt = '0; state_nxt = S_STAT_RD;
            end else begin
              state_nxt = S_REL_PREV_CHK;
              idx_nxt   = hit_r - CntW'(1);
            end
            raddr = idx_nxt[IdxW-1:0];
          end
        end else begin
          state_nxt = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        we = 1'b1;
        wdata = rdata;
        if (mode_r) begin
          waddr   = IdxW'(idx_r + CntW'(1));
          idx_nxt = idx_r - CntW'(1);
        end else begin
          waddr   = IdxW'(idx_r - CntW'(1));
          idx_nxt = idx_r + CntW'(1);
        end
        raddr = idx_nxt[IdxW-1:0];
        state_nxt = S_SHIFT_RD;
      end
      // mark the chosen block allocated
      S_SPLIT: begin
        we        = 1'b1;
        waddr     = hit_r[IdxW-1:0];
        wdata     = '{offset: cur_r.offset, size: cur_r.size, free: 1'b0};
        used_nxt  = used_r + cur_r.size;
        addr_nxt  = base_r + 32'(cur_r.offset) + 32'(HeaderBytes);
        idx_nxt   = '0;
        state_nxt = S_STAT_RD;
      end
      S_REL_NEXT: begin
        state_nxt = S_REL_NEXT_CHK;
      end
      // mark the block free and merge with a free successor
      S_REL_NEXT_CHK: begin
        we    = 1'b1;
        waddr = hit_r[IdxW-1:0];
        if (idx_r < count_r && rdata.free) begin
          cur_nxt = '{offset: cur_r.offset,
                      size: cur_r.size + OffW'(HeaderBytes) + rdata.size, free: 1'b1};
          wdata   = cur_nxt;
          mode_nxt  = 1'b0;
          idx_nxt   = idx_r + CntW'(1);
          raddr     = idx_nxt[IdxW-1:0];
          state_nxt = S_SHIFT_RD;
        end else begin
          cur_nxt   = '{offset: cur_r.offset, size: cur_r.size, free: 1'b1};
          wdata     = cur_nxt;
          idx_nxt   = hit_r - CntW'(1);
          raddr     = idx_nxt[IdxW-1:0];
          state_nxt = S_REL_PREV_CHK;
        end
        if (hit_r == '0) begin
          phase_nxt = 1'b1;
        end
      end
      // merge into a free predecessor
      S_REL_PREV_CHK: begin
        if (hit_r == '0 || phase_r) begin
          idx_nxt = '0; state_nxt = S_STAT_RD;
        end else if (!(idx_r == hit_r - CntW'(1))) begin
          idx_nxt = hit_r - CntW'(1);
        end else if (rdata.free) begin
          we        = 1'b1;
          waddr     = idx_r[IdxW-1:0];
          wdata     = '{offset: rdata.offset,
                        size: rdata.size + OffW'(HeaderBytes) + cur_r.size, free: 1'b1};
          phase_nxt = 1'b1;
          mode_nxt  = 1'b0;
          idx_nxt   = hit_r + CntW'(1);
          raddr     = idx_nxt[IdxW-1:0];
          state_nxt = S_SHIFT_RD;
        end else begin
          idx_nxt = '0; state_nxt = S_STAT_RD;
        end
      end
      // statistics pass
      S_STAT_RD: begin
        if (idx_r == '0) begin
          nfree_nxt = '0;
          big_nxt   = '0;
        end
        if (idx_r >= count_r) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_STAT;
        end
      end
      S_STAT: begin
        if (rdata.free) begin
          nfree_nxt = nfree_r + CntW'(1);
          if (rdata.size > big_r) big_nxt = rdata.size;
        end
        idx_nxt   = idx_r + CntW'(1);
        raddr     = idx_nxt[IdxW-1:0];
        state_nxt = S_STAT_RD;
      end
      S_DONE: begin
        oval_nxt  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      bytes_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_BASE:  base_r  <= cfg_ch.data;
        CFG_BYTES: bytes_r <= cfg_ch.data[20:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      used_r  <= '0;
      ready_r <= 1'b0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      used_r  <= used_nxt;
      ready_r <= ready_nxt;
      oval_r  <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    need_r  <= need_nxt;
    rel_r   <= rel_nxt;
    idx_r   <= idx_nxt;
    hit_r   <= hit_nxt;
    stop_r  <= stop_nxt;
    hold_r  <= hold_nxt;
    cur_r   <= cur_nxt;
    mode_r  <= mode_nxt;
    phase_r <= phase_nxt;
    st_r    <= st_nxt;
    addr_r  <= addr_nxt;
    nfree_r <= nfree_nxt;
    big_r   <= big_nxt;
  end

  // checks
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(MaxBlocks)) else $error("table count overflow");
  a_free_le: assert property (@(posedge clk) disable iff (!rst_n)
    oval_r |-> nfree_r <= count_r) else $error("free count above total");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    oval_r && !out_ch.ready |=> oval_r && $stable(st_r)) else $error("result dropped");
  a_grant: assert property (@(posedge clk) disable iff (!rst_n)
    oval_r && st_r != ST_OK |-> addr_r == '0) else $error("address on failure");

endmodule
